/* src/moving_average_delay_reporter_defines.svh */
// Assertion macros used by the checker file of the delay reporter.
`ifndef MOVING_AVERAGE_DELAY_REPORTER_DEFINES_SVH
`define MOVING_AVERAGE_DELAY_REPORTER_DEFINES_SVH

// A property that is checked only outside reset.
`define MAD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A property that is checked during reset as well.
`define MAD_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/mad_pkg.sv */
package mad_pkg;

	localparam int DELAY_W     = 24;
	localparam int RATE_W      = 19;
	localparam int INTERVAL_W  = 16;
	localparam int TENTHS_W    = 15;
	localparam int CMD_W       = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 19;

	// The divider covers the widest dividend, the scaled average.
	localparam int SCALE_W   = 14;
	localparam int DIV_W     = DELAY_W + SCALE_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [SCALE_W-1:0]    TENTHS_SCALE = SCALE_W'(10000);
	localparam logic [TENTHS_W-1:0]   MAX_TENTHS   = '1;
	localparam logic [INTERVAL_W-1:0] TICK_MAX     = '1;

	localparam logic [RATE_W-1:0]     RESET_SAMPLE_RATE = RATE_W'(48000);
	localparam logic [INTERVAL_W-1:0] RESET_MIN_TICKS   = INTERVAL_W'(1000);
	localparam logic [TENTHS_W-1:0]   RESET_THRESHOLD   = TENTHS_W'(100);

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SAMPLE_RATE = 2'd0,
		REG_MIN_TICKS   = 2'd1,
		REG_THRESHOLD   = 2'd2
	} reg_index_t;

	// Datapath operation of one microcode step.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_APPLY,
		OP_LOAD_AVG,
		OP_DIV,
		OP_SAVE_AVG,
		OP_MUL,
		OP_LOAD_CONV,
		OP_SAVE_TENTHS,
		OP_PUBLISH
	} op_t;

	// Jump condition: when it holds the step counter loads the target,
	// otherwise it moves on to the next step.
	typedef enum logic [2:0] {
		CND_NEXT,
		CND_WAIT_IN,
		CND_DIV_LOOP,
		CND_WAIT_OUT,
		CND_ALWAYS
	} cond_t;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE        = 4'd0;
	localparam step_t STEP_APPLY       = 4'd1;
	localparam step_t STEP_LOAD_AVG    = 4'd2;
	localparam step_t STEP_DIV_AVG     = 4'd3;
	localparam step_t STEP_SAVE_AVG    = 4'd4;
	localparam step_t STEP_MUL         = 4'd5;
	localparam step_t STEP_LOAD_CONV   = 4'd6;
	localparam step_t STEP_DIV_CONV    = 4'd7;
	localparam step_t STEP_SAVE_TENTHS = 4'd8;
	localparam step_t STEP_WAIT_OUT    = 4'd9;
	localparam step_t STEP_PUBLISH     = 4'd10;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	// The control program.
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		unique case (step)
			STEP_IDLE:        w = '{OP_NONE,        CND_WAIT_IN,  STEP_IDLE};
			STEP_APPLY:       w = '{OP_APPLY,       CND_NEXT,     STEP_IDLE};
			STEP_LOAD_AVG:    w = '{OP_LOAD_AVG,    CND_NEXT,     STEP_IDLE};
			STEP_DIV_AVG:     w = '{OP_DIV,         CND_DIV_LOOP, STEP_DIV_AVG};
			STEP_SAVE_AVG:    w = '{OP_SAVE_AVG,    CND_NEXT,     STEP_IDLE};
			STEP_MUL:         w = '{OP_MUL,         CND_NEXT,     STEP_IDLE};
			STEP_LOAD_CONV:   w = '{OP_LOAD_CONV,   CND_NEXT,     STEP_IDLE};
			STEP_DIV_CONV:    w = '{OP_DIV,         CND_DIV_LOOP, STEP_DIV_CONV};
			STEP_SAVE_TENTHS: w = '{OP_SAVE_TENTHS, CND_NEXT,     STEP_IDLE};
			STEP_WAIT_OUT:    w = '{OP_NONE,        CND_WAIT_OUT, STEP_WAIT_OUT};
			STEP_PUBLISH:     w = '{OP_PUBLISH,     CND_ALWAYS,   STEP_IDLE};
			default:          w = '{OP_NONE,        CND_ALWAYS,   STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

/* src/mad_ifs.sv */
interface mad_in_if;
	import mad_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [DELAY_W-1:0] delay_frames;
	modport source (output valid, command, delay_frames, input ready);
	modport sink (input valid, command, delay_frames, output ready);
endinterface

interface mad_out_if;
	import mad_pkg::*;
	logic                valid;
	logic                ready;
	logic [DELAY_W-1:0]  average_frames;
	logic [TENTHS_W-1:0] delay_tenths_ms;
	logic                published;
	logic [TENTHS_W-1:0] reported_value;
	modport source (output valid, average_frames, delay_tenths_ms, published,
		reported_value, input ready);
	modport sink (input valid, average_frames, delay_tenths_ms, published,
		reported_value, output ready);
endinterface

interface mad_cfg_if;
	import mad_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/moving_average_delay_reporter.sv */
// One transaction at a time: the input stands ready only in the idle step, so a new
// transaction is taken only after the program has published the previous result; the
// one shared divider, which retires one quotient bit a cycle, runs twice per item.
// Reset (arst_n low) restores the register defaults, empties the window, saturates
// the tick counter and zeroes the reported value; the window memory needs no sweep.
module moving_average_delay_reporter #(
	parameter int WINDOW_SIZE = 64
) (
	input logic      clk,
	input logic      arst_n,
	mad_in_if.sink   req,
	mad_out_if.source rsp,
	mad_cfg_if.sink  cfg
);
	import mad_pkg::*;

	localparam int SLOT_W    = $clog2(WINDOW_SIZE);
	localparam int SEEN_W    = $clog2(WINDOW_SIZE + 1);
	localparam int SUM_W     = DELAY_W + $clog2(WINDOW_SIZE);

	// Configuration registers. The user must write them only while the block is idle;
	// the block itself does not enforce this, and the port always stands ready.
	logic [RATE_W-1:0]     rate_q;
	logic [INTERVAL_W-1:0] min_ticks_q;
	logic [TENTHS_W-1:0]   threshold_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= RESET_SAMPLE_RATE;
			min_ticks_q <= RESET_MIN_TICKS;
			threshold_q <= RESET_THRESHOLD;
		end else if (cfg.valid) begin
			unique case (reg_index_t'(cfg.index))
				REG_SAMPLE_RATE: rate_q      <= cfg.data[RATE_W-1:0];
				REG_MIN_TICKS:   min_ticks_q <= cfg.data[INTERVAL_W-1:0];
				REG_THRESHOLD:   threshold_q <= cfg.data[TENTHS_W-1:0];
				default: ;
			endcase
		end
	end

	// Microcode sequencer: the step counter addresses the control store, and
	// the control word picks one datapath operation and a conditional jump.
	step_t  pc_q;
	uword_t uw;
	logic   in_accept;
	logic   out_take;
	logic   jump;

	logic                 out_valid_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	assign uw        = ucode(pc_q);
	assign req.ready = (pc_q == STEP_IDLE);
	assign in_accept = req.valid && req.ready;
	assign out_take  = out_valid_q && rsp.ready;

	always_comb begin
		unique case (uw.cond)
			CND_NEXT:     jump = 1'b0;
			CND_WAIT_IN:  jump = !in_accept;
			CND_DIV_LOOP: jump = (div_cnt_q != DIV_CNT_W'(1));
			CND_WAIT_OUT: jump = out_valid_q && !rsp.ready;
			CND_ALWAYS:   jump = 1'b1;
			default:      jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= jump ? uw.target : pc_q + 1'b1;
		end
	end

	// The accepted transaction is held for the whole run of the program.
	cmd_t               cmd_q;
	logic [DELAY_W-1:0] delay_q;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q   <= cmd_t'(req.command);
			delay_q <= req.delay_frames;
		end
	end

	// Window memory. Entries at or beyond the fill count have not been written
	// since the window was last emptied and count as zero: while the window is
	// filling, the write slot equals the fill count, so only a full window ever
	// overwrites a live entry. The read of the current slot is registered and is
	// settled well before the apply step uses it.
	logic [DELAY_W-1:0] window_mem [WINDOW_SIZE];
	logic [DELAY_W-1:0] old_rd_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SEEN_W-1:0]  seen_q;
	logic [SUM_W-1:0]   sum_q;
	logic               window_full;
	logic [DELAY_W-1:0] old_value;

	assign window_full = (seen_q == SEEN_W'(WINDOW_SIZE));
	assign old_value   = window_full ? old_rd_q : '0;

	always_ff @(posedge clk) begin
		old_rd_q <= window_mem[slot_q];
		if (uw.op == OP_APPLY && cmd_q == CMD_SAMPLE) begin
			window_mem[slot_q] <= delay_q;
		end
	end

	// Shared restoring divider, one quotient bit a cycle. The dividend shifts
	// out of the top of the quotient register as the quotient shifts in. A zero
	// divisor yields all ones, which the conversion turns into saturation.
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] dvs_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  prod_q;
	logic [RATE_W:0]   rem_sh;
	logic [RATE_W:0]   rem_sub;
	logic              quo_bit;

	assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
	assign quo_bit = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = quo_bit ? rem_sh - {1'b0, dvs_q} : rem_sh;

	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_LOAD_AVG: begin
				rem_q <= '0;
				dvs_q <= RATE_W'(seen_q);
				quo_q <= DIV_W'(sum_q);
			end
			OP_LOAD_CONV: begin
				rem_q <= '0;
				dvs_q <= rate_q;
				quo_q <= prod_q;
			end
			OP_DIV: begin
				rem_q <= rem_sub[RATE_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], quo_bit};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (uw.op == OP_LOAD_AVG || uw.op == OP_LOAD_CONV) begin
			div_cnt_q <= DIV_CNT_W'(DIV_W);
		end else if (uw.op == OP_DIV) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	// Average, its scaling by ten thousand, and the saturated conversion.
	logic [DELAY_W-1:0]  avg_q;
	logic [TENTHS_W-1:0] tenths_q;
	logic [TENTHS_W-1:0] tenths_sat;

	assign tenths_sat = (quo_q[DIV_W-1:TENTHS_W] != '0) ? MAX_TENTHS
		: quo_q[TENTHS_W-1:0];

	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_SAVE_AVG:    avg_q    <= (seen_q == '0) ? '0 : quo_q[DELAY_W-1:0];
			OP_MUL:         prod_q   <= DIV_W'(avg_q) * DIV_W'(TENTHS_SCALE);
			OP_SAVE_TENTHS: tenths_q <= tenths_sat;
			default: ;
		endcase
	end

	// Publish decision: enough ticks since the last report and a change of at
	// least the threshold. Only a sample transaction may publish.
	logic [INTERVAL_W-1:0] ticks_q;
	logic [TENTHS_W-1:0]   last_q;
	logic [TENTHS_W-1:0]   diff;
	logic                  publish;

	assign diff    = (tenths_q > last_q) ? tenths_q - last_q : last_q - tenths_q;
	assign publish = (cmd_q == CMD_SAMPLE) && (ticks_q >= min_ticks_q)
		&& (diff >= threshold_q);

	// Window bookkeeping, tick counter and reported value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			seen_q  <= '0;
			sum_q   <= '0;
			ticks_q <= TICK_MAX;
			last_q  <= '0;
		end else if (uw.op == OP_APPLY) begin
			unique case (cmd_q)
				CMD_SAMPLE: begin
					sum_q  <= sum_q - SUM_W'(old_value) + SUM_W'(delay_q);
					slot_q <= (slot_q == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_q + 1'b1;
					if (!window_full) begin
						seen_q <= seen_q + 1'b1;
					end
				end
				CMD_TICK: begin
					if (ticks_q != TICK_MAX) begin
						ticks_q <= ticks_q + 1'b1;
					end
				end
				CMD_CLEAR: begin
					slot_q <= '0;
					seen_q <= '0;
					sum_q  <= '0;
				end
				CMD_NOP: ;
				default: ;
			endcase
		end else if (uw.op == OP_PUBLISH && publish) begin
			ticks_q <= '0;
			last_q  <= tenths_q;
		end
	end

	// Output register. The sequencer waits before the publish step until the
	// previous result transaction has been taken, so a result is never lost.
	logic [DELAY_W-1:0]  out_avg_q;
	logic [TENTHS_W-1:0] out_tenths_q;
	logic                out_pub_q;
	logic [TENTHS_W-1:0] out_rep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.op == OP_PUBLISH) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == OP_PUBLISH) begin
			out_avg_q    <= avg_q;
			out_tenths_q <= tenths_q;
			out_pub_q    <= publish;
			out_rep_q    <= publish ? tenths_q : last_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.average_frames  = out_avg_q;
	assign rsp.delay_tenths_ms = out_tenths_q;
	assign rsp.published       = out_pub_q;
	assign rsp.reported_value  = out_rep_q;

endmodule

/* src/mad_checker.sv */
`include "moving_average_delay_reporter_defines.svh"

module mad_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [mad_pkg::DELAY_W-1:0]    rsp_average_frames,
	input logic [mad_pkg::TENTHS_W-1:0]   rsp_delay_tenths_ms,
	input logic                           rsp_published,
	input logic [mad_pkg::TENTHS_W-1:0]   rsp_reported_value
);
	import mad_pkg::*;

	// A result that has not been taken keeps its contents.
	`MAD_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average_frames) && $stable(rsp_delay_tenths_ms) && $stable(rsp_published) && $stable(rsp_reported_value), "result changed while stalled")

	// A published result reports the value it has just converted.
	`MAD_ASSERT(a_pub_value, clk, arst_n, rsp_valid && rsp_published |-> rsp_reported_value == rsp_delay_tenths_ms, "published value differs from conversion")

	// One item at a time: the input closes right after a transaction.
	`MAD_ASSERT(a_one_item, clk, arst_n, req_valid && req_ready |=> !req_ready, "input still open after a transaction")

	// No result is offered while reset is applied.
	`MAD_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !rsp_valid, "result offered during reset")

endmodule

bind moving_average_delay_reporter mad_checker u_mad_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_average_frames  (rsp.average_frames),
	.rsp_delay_tenths_ms (rsp.delay_tenths_ms),
	.rsp_published       (rsp.published),
	.rsp_reported_value  (rsp.reported_value)
);

/* bench/moving_average_delay_reporter_tb.sv */
`timescale 1ns / 1ps

module moving_average_delay_reporter_tb;
	import mad_pkg::*;

	localparam int WINDOW        = 64;
	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 4;
	localparam int IDLE_PERCENT  = 29;
	// The quiet spell after the last result is comfortably longer than one run of the
	// block's program for a transaction.
	localparam int SETTLE_CYCLES = 200;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASE_ITEMS   = 130;
	localparam int PHASES        = 7;
	localparam longint unsigned TENTHS_PER_SECOND = 10000;

	// One result transaction, laid out as the result channel carries it.
	typedef struct packed {
		logic [DELAY_W-1:0]  average;
		logic [TENTHS_W-1:0] tenths;
		logic                published;
		logic [TENTHS_W-1:0] reported;
	} delay_report_t;

	// One row of the directed table. Where 'typed' is set, the expected report is
	// written out by hand; otherwise it comes from the predictor.
	typedef struct packed {
		cmd_t          cmd;
		logic [DELAY_W-1:0] delay;
		logic          typed;
		delay_report_t want;
	} probe_t;

	// Register settings for one phase of the random part.
	typedef struct packed {
		logic [RATE_W-1:0]     rate;
		logic [INTERVAL_W-1:0] min_ticks;
		logic [TENTHS_W-1:0]   threshold;
	} setting_t;

	logic clk;
	logic arst_n;

	mad_in_if  req_ch ();
	mad_out_if rsp_ch ();
	mad_cfg_if cfg_ch ();

	moving_average_delay_reporter #(
		.WINDOW_SIZE(WINDOW)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// Shadow copy of the block's state and registers, kept in step with every
	// accepted transaction.
	logic [DELAY_W-1:0]    win_frames [WINDOW];
	int                    win_slot;
	int                    win_count;
	longint unsigned       win_total;
	logic [INTERVAL_W-1:0] ticks_waited;
	logic [TENTHS_W-1:0]   last_published;
	logic [RATE_W-1:0]     cfg_rate;
	logic [INTERVAL_W-1:0] cfg_min_ticks;
	logic [TENTHS_W-1:0]   cfg_threshold;

	// Reports that have been predicted but not yet seen on the result channel.
	delay_report_t pending_reports [$];

	int  mismatches;
	int  cycle_count;
	// Set while both sides are to run flat out, with no idle cycles at all.
	bit  steady_flow;

	// After reset the window is empty, the tick counter is saturated and nothing
	// has been reported. Then come the extremes of the delay field, every command,
	// the unused command code and a clear that keeps the reported value.
	probe_t directed_probes [15] = '{
		'{CMD_TICK,   24'd0,        1'b1, '{24'd0,       15'd0,     1'b0, 15'd0}},
		'{CMD_NOP,    24'hFFFFFF,   1'b1, '{24'd0,       15'd0,     1'b0, 15'd0}},
		'{CMD_CLEAR,  24'd0,        1'b1, '{24'd0,       15'd0,     1'b0, 15'd0}},
		'{CMD_SAMPLE, 24'd48000,    1'b1, '{24'd48000,   15'd10000, 1'b1, 15'd10000}},
		'{CMD_SAMPLE, 24'd48000,    1'b1, '{24'd48000,   15'd10000, 1'b0, 15'd10000}},
		'{CMD_SAMPLE, 24'hFFFFFF,   1'b1, '{24'd5624405, 15'd32767, 1'b0, 15'd10000}},
		'{CMD_SAMPLE, 24'd0,        1'b0, '0},
		'{CMD_TICK,   24'h123456,   1'b0, '0},
		'{CMD_CLEAR,  24'hFFFFFF,   1'b1, '{24'd0,       15'd0,     1'b0, 15'd10000}},
		'{CMD_SAMPLE, 24'd0,        1'b0, '0},
		'{CMD_SAMPLE, 24'd1,        1'b0, '0},
		'{CMD_SAMPLE, 24'hAAAAAA,   1'b0, '0},
		'{CMD_SAMPLE, 24'h555555,   1'b0, '0},
		'{CMD_NOP,    24'd0,        1'b0, '0},
		'{CMD_SAMPLE, 24'h800000,   1'b0, '0}
	};

	// Phase settings: the register extremes, a zero sample rate, a rate above the
	// usual range and a few ordinary audio rates. The last row is drawn at random.
	setting_t phase_plan [PHASES] = '{
		'{19'd48000,  16'd3,     15'd10},
		'{19'd1,      16'd0,     15'd0},
		'{19'd0,      16'd1,     15'd32767},
		'{19'd524287, 16'd65535, 15'd0},
		'{19'd384000, 16'd0,     15'd1},
		'{19'd44100,  16'd5,     15'd50},
		'{19'd48000,  16'd2,     15'd20}
	};

	always #HALF_PERIOD clk = ~clk;

	// Prints one line per mismatch and counts every one.
	task automatic note_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] seen);
		mismatches++;
		$display("[%0t] delay report mismatch, %s: expected %0d, saw %0d",
			$time, what, want, seen);
	endtask

	// Applies one command to the shadow state and returns the report that the
	// block must produce for it.
	function automatic delay_report_t predict_report(input cmd_t cmd,
		input logic [DELAY_W-1:0] delay);
		delay_report_t   r;
		logic [DELAY_W-1:0]  avg;
		logic [TENTHS_W-1:0] tenths;
		longint unsigned scaled;
		int unsigned     gap;
		case (cmd)
			CMD_SAMPLE: begin
				win_total = win_total - win_frames[win_slot] + delay;
				win_frames[win_slot] = delay;
				win_slot = (win_slot + 1) % WINDOW;
				if (win_count < WINDOW)
					win_count++;
			end
			CMD_TICK: begin
				if (ticks_waited != TICK_MAX)
					ticks_waited++;
			end
			CMD_CLEAR: begin
				foreach (win_frames[i])
					win_frames[i] = '0;
				win_slot = 0;
				win_count = 0;
				win_total = 0;
			end
			default: begin
			end
		endcase

		avg = (win_count == 0) ? '0 : DELAY_W'(win_total / longint'(win_count));

		// A zero rate has no sensible conversion, so the block pins it at the top.
		if (cfg_rate == '0) begin
			tenths = MAX_TENTHS;
		end else begin
			scaled = (longint'(avg) * TENTHS_PER_SECOND) / longint'(cfg_rate);
			tenths = (scaled > longint'(MAX_TENTHS)) ? MAX_TENTHS : TENTHS_W'(scaled);
		end

		r.published = 1'b0;
		if (cmd == CMD_SAMPLE) begin
			gap = (tenths > last_published) ? tenths - last_published
				: last_published - tenths;
			if (ticks_waited >= cfg_min_ticks && gap >= cfg_threshold) begin
				r.published = 1'b1;
				ticks_waited = '0;
				last_published = tenths;
			end
		end
		r.average = avg;
		r.tenths = tenths;
		r.reported = last_published;
		return r;
	endfunction

	// Offers one command, possibly after some idle cycles, and waits for it to be
	// taken. The valid line is left high, so that a following command can go
	// straight out at the same edge.
	task automatic issue_command(input cmd_t cmd, input logic [DELAY_W-1:0] delay,
		input logic typed, input delay_report_t typed_want);
		delay_report_t r;
		while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= cmd;
		req_ch.delay_frames <= delay;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		r = predict_report(cmd, delay);
		pending_reports.push_back(typed ? typed_want : r);
	endtask

	// Writes one register and leaves valid high for the next write.
	task automatic put_register(input reg_index_t index, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (index)
			REG_SAMPLE_RATE: cfg_rate = RATE_W'(data);
			REG_MIN_TICKS:   cfg_min_ticks = INTERVAL_W'(data);
			REG_THRESHOLD:   cfg_threshold = TENTHS_W'(data);
			default: begin
			end
		endcase
	endtask

	// Waits until every predicted report has come back, then lets the block sit
	// for longer than its latency so that it is certainly idle.
	task automatic settle_block();
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Most delays sit around one second's worth of frames, so that the converted
	// value stays in range and drifts by amounts close to the threshold. The rest
	// are anything at all, or the two extremes.
	function automatic logic [DELAY_W-1:0] pick_delay(input int unsigned centre);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return DELAY_W'(centre / 2 + $urandom_range(0, centre));
		else if (roll < 90)
			return DELAY_W'($urandom);
		else if (roll < 95)
			return '0;
		else
			return '1;
	endfunction

	// Result side: every accepted result transaction is checked against the
	// oldest prediction, and ready idles at random except in the steady stretch.
	always @(posedge clk) begin
		delay_report_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_reports.size() == 0) begin
				note_mismatch("result with nothing pending", 32'd0,
					32'(rsp_ch.average_frames));
			end else begin
				want = pending_reports.pop_front();
				if (rsp_ch.average_frames !== want.average)
					note_mismatch("average_frames", 32'(want.average),
						32'(rsp_ch.average_frames));
				if (rsp_ch.delay_tenths_ms !== want.tenths)
					note_mismatch("delay_tenths_ms", 32'(want.tenths),
						32'(rsp_ch.delay_tenths_ms));
				if (rsp_ch.published !== want.published)
					note_mismatch("published", 32'(want.published),
						32'(rsp_ch.published));
				if (rsp_ch.reported_value !== want.reported)
					note_mismatch("reported_value", 32'(want.reported),
						32'(rsp_ch.reported_value));
			end
		end
		rsp_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Watchdog: a block that hangs or drops a result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		cmd_t               cmd;
		logic [DELAY_W-1:0] delay;
		int unsigned        centre;
		int unsigned        roll;
		int                 counted;

		clk                 = 1'b0;
		arst_n              = 1'b1;
		req_ch.valid        = 1'b0;
		req_ch.command      = CMD_NOP;
		req_ch.delay_frames = '0;
		rsp_ch.ready        = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_SAMPLE_RATE;
		cfg_ch.data         = '0;
		mismatches          = 0;
		cycle_count         = 0;
		steady_flow         = 1'b0;

		// The shadow state starts where reset leaves the block.
		foreach (win_frames[i])
			win_frames[i] = '0;
		win_slot       = 0;
		win_count      = 0;
		win_total      = 0;
		ticks_waited   = TICK_MAX;
		last_published = '0;
		cfg_rate       = RESET_SAMPLE_RATE;
		cfg_min_ticks  = RESET_MIN_TICKS;
		cfg_threshold  = RESET_THRESHOLD;

		// The last phase uses registers drawn at random within the usual ranges.
		phase_plan[PHASES-1].rate      = RATE_W'($urandom_range(1, 384000));
		phase_plan[PHASES-1].min_ticks = INTERVAL_W'($urandom_range(0, 6));
		phase_plan[PHASES-1].threshold = TENTHS_W'($urandom_range(0, 200));

		// Reset goes low a moment after start, so that every process sees its
		// falling edge before the first clock edge.
		#1 arst_n = 1'b0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run with the reset register values.
		foreach (directed_probes[i])
			issue_command(directed_probes[i].cmd, directed_probes[i].delay,
				directed_probes[i].typed, directed_probes[i].want);
		req_ch.valid <= 1'b0;
		settle_block();

		// Random part. Each phase rewrites all three registers while the block is
		// idle, then runs a mix of samples and ticks, so that publishing is both
		// allowed and refused, with the odd clear and unused command thrown in.
		for (int p = 0; p < PHASES; p++) begin
			put_register(REG_SAMPLE_RATE, CFG_DATA_W'(phase_plan[p].rate));
			put_register(REG_MIN_TICKS, CFG_DATA_W'(phase_plan[p].min_ticks));
			put_register(REG_THRESHOLD, CFG_DATA_W'(phase_plan[p].threshold));
			cfg_ch.valid <= 1'b0;

			centre = (phase_plan[p].rate < 1000) ? 20000 : int'(phase_plan[p].rate);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				// The first phase opens with a stretch in which neither side idles.
				steady_flow = (p == 0 && counted < 60);
				roll = $urandom_range(99);
				delay = pick_delay(centre);
				if (roll < 50)
					cmd = CMD_SAMPLE;
				else if (roll < 88)
					cmd = CMD_TICK;
				else if (roll < 94)
					cmd = CMD_CLEAR;
				else
					cmd = CMD_NOP;
				issue_command(cmd, delay, 1'b0, '0);
				if (cmd != CMD_NOP)
					counted++;
			end
			steady_flow = 1'b0;
			req_ch.valid <= 1'b0;
			settle_block();
		end

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
